>>> rtl/bxa_pkg.sv
// Package for the boxcar average block: op codes, reply constants and the
// request struct handed from the top level to the reply buffer.
// No dependencies.
package bxa_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned AVG_OUT_W = 16;
  localparam int unsigned LEN_W     = 2;
  localparam int unsigned AVG_SHIFT = 5;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [BYTE_W-1:0] CMD_AVERAGE = 8'h63;
  localparam logic [BYTE_W-1:0] REPLY_OTHER = 8'd66;
  localparam logic [BYTE_W-1:0] REPLY_EMPTY = 8'd88;
  localparam logic [LEN_W-1:0]  REPLY_BYTES = 2'd2;

  typedef struct packed {
    logic              load;
    logic              cmd_present;
    logic [BYTE_W-1:0] cmd_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] high;
    logic [BYTE_W-1:0] low;
  } reply_t;

endpackage

>>> rtl/bxa_cell.sv
// One window cell: holds a single converter sample and passes it to the
// next cell on every shift. Depends on bxa_pkg.
module bxa_cell
  import bxa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [SAMPLE_W-1:0] d_in,
  output logic [SAMPLE_W-1:0] q_out
);

  logic [SAMPLE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign q_out = data_r;

endmodule

>>> rtl/bxa_accum.sv
// Running window sum: adds the new sample and drops the one leaving the
// end of the cell chain; also forms the 16-bit average. Depends on bxa_pkg.
module bxa_accum
  import bxa_pkg::*;
#(
  parameter int unsigned SUM_W = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  logic [SAMPLE_W-1:0]  new_sample,
  input  logic [SAMPLE_W-1:0]  old_sample,
  output logic [AVG_OUT_W-1:0] avg
);

  localparam int unsigned AVG_W = SUM_W - AVG_SHIFT;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;

  // intermediate may wrap, the final total is exact
  assign sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(new_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (shift_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign avg = {{(AVG_OUT_W-AVG_W){1'b0}}, sum_r[SUM_W-1:AVG_SHIFT]};

endmodule

>>> rtl/bxa_reply.sv
// Reply formatting and output buffer: an output register plus one skid
// entry so a stalled reply does not block the input. Depends on bxa_pkg.
module bxa_reply
  import bxa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  req_t                 req,
  input  logic [AVG_OUT_W-1:0] avg,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_reply_high,
  output logic [BYTE_W-1:0]    out_reply_low
);

  reply_t fmt;
  reply_t out_r;
  reply_t skid_r;
  logic   out_valid_r;
  logic   skid_valid_r;

  always_comb begin
    if (!req.cmd_present) begin
      fmt.high = REPLY_EMPTY;
      fmt.low  = REPLY_EMPTY;
    end else if (req.cmd_byte == CMD_AVERAGE) begin
      fmt.high = avg[AVG_OUT_W-1:BYTE_W];
      fmt.low  = avg[BYTE_W-1:0];
    end else begin
      fmt.high = REPLY_OTHER;
      fmt.low  = REPLY_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      // output slot frees up: skid first, else the new request
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= fmt;
        out_valid_r <= req.load;
      end
    end else if (req.load) begin
      skid_r       <= fmt;
      skid_valid_r <= 1'b1;
    end
  end

  assign busy           = skid_valid_r;
  assign out_valid      = out_valid_r;
  assign out_reply_high = out_r.high;
  assign out_reply_low  = out_r.low;

endmodule

>>> rtl/boxcar_average_with_read_port_unit.sv
// Boxcar average with a read port: top level.
// Channels: the input channel carries samples (in_op = 0) and read
// requests (in_op = 1); the output channel carries one two-byte reply per
// request and nothing for a sample. Both use valid/stall, an item moving
// when valid is high and stall is low.
// Samples shift into a chain of WINDOW_DEPTH cells; the cell at the end
// drops out of the running sum as the new one enters, one sample a cycle
// while in_stall is low. A request is answered from the sum as it stands
// at acceptance; its reply is registered in the output or skid entry, and
// one item can be accepted every cycle while in_stall is low.
// When the receiver stalls, the reply holds in the output register and one
// more request fits in a skid entry; in_stall rises only while that entry
// is full and drops the cycle after the output moves.
// Reset (synchronous, active low) clears every cell and the sum and empties
// both output entries.
// Depends on bxa_pkg, bxa_cell, bxa_accum and bxa_reply.
module boxcar_average_with_read_port_unit
  import bxa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_cmd_present,
  input  logic [BYTE_W-1:0]   in_cmd_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_reply_high,
  output logic [BYTE_W-1:0]   out_reply_low,
  output logic [LEN_W-1:0]    out_reply_length
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  logic                 in_accept;
  logic                 shift_en;
  logic                 busy;
  logic [SAMPLE_W-1:0]  tap [WINDOW_DEPTH+1];
  logic [AVG_OUT_W-1:0] avg;
  req_t                 req;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign shift_en  = in_accept && (in_op == OP_SAMPLE);

  assign tap[0] = in_sample;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    bxa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (tap[i]),
      .q_out    (tap[i+1])
    );
  end

  bxa_accum #(
    .SUM_W (SUM_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (shift_en),
    .new_sample (in_sample),
    .old_sample (tap[WINDOW_DEPTH]),
    .avg        (avg)
  );

  assign req.load        = in_accept && (in_op == OP_REQUEST);
  assign req.cmd_present = in_cmd_present;
  assign req.cmd_byte    = in_cmd_byte;

  bxa_reply u_reply (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .avg            (avg),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reply_high (out_reply_high),
    .out_reply_low  (out_reply_low)
  );

  assign out_reply_length = REPLY_BYTES;

endmodule

>>> rtl/bxa_checker.sv
// Port-level checks for the boxcar average block, bound to the top level.
// Depends on bxa_pkg and boxcar_average_with_read_port_unit.
module bxa_checker
  import bxa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_op,
  input logic              in_cmd_present,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_reply_high,
  input logic [BYTE_W-1:0] out_reply_low,
  input logic [LEN_W-1:0]  out_reply_length
);

  // a stalled reply holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reply_high)
      && $stable(out_reply_low) && $stable(out_reply_length)))
    else $error("stalled reply changed");

  // input only backs up behind a pending reply
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid && in_op == OP_REQUEST))
    else $error("input stall without a blocked request");

  // empty request into an idle output answers 88,88 next cycle
  a_empty_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_REQUEST && !in_cmd_present && !out_valid)
      |=> (out_valid && out_reply_high == REPLY_EMPTY && out_reply_low == REPLY_EMPTY))
    else $error("empty request reply wrong");

endmodule

bind boxcar_average_with_read_port_unit bxa_checker u_bxa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_op            (in_op),
  .in_cmd_present   (in_cmd_present),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_reply_high   (out_reply_high),
  .out_reply_low    (out_reply_low),
  .out_reply_length (out_reply_length)
);

>>> dv/tb.sv
// Testbench for boxcar_average_with_read_port_unit: samples and read requests go in,
// and each reply is checked against a running 32-sample window kept here.
// Depends on bxa_pkg and the rtl of the block.
`timescale 1ns / 100ps

module tb;
  import bxa_pkg::*;

  localparam int unsigned WINDOW_DEPTH   = 32;
  localparam int unsigned PTR_W          = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W          = SAMPLE_W + PTR_W;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 4;

  typedef struct {
    logic [BYTE_W-1:0] high;
    logic [BYTE_W-1:0] low;
    logic [LEN_W-1:0]  length;
  } reply_exp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = OP_SAMPLE;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_cmd_present = 1'b0;
  logic [BYTE_W-1:0]   in_cmd_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_reply_high;
  logic [BYTE_W-1:0]   out_reply_low;
  logic [LEN_W-1:0]    out_reply_length;

  // window copy kept alongside the block
  logic [SAMPLE_W-1:0] win_ring [WINDOW_DEPTH];
  logic [SUM_W-1:0]    win_sum = '0;
  logic [PTR_W-1:0]    win_ptr = '0;
  reply_exp_t          pending_replies[$];

  bit          no_idle = 1'b0;
  int unsigned error_count = 0;
  int unsigned n_samples = 0;
  int unsigned n_requests = 0;
  int unsigned n_replies = 0;
  int unsigned idle_cycles = 0;

  boxcar_average_with_read_port_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_sample        (in_sample),
    .in_cmd_present   (in_cmd_present),
    .in_cmd_byte      (in_cmd_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_high   (out_reply_high),
    .out_reply_low    (out_reply_low),
    .out_reply_length (out_reply_length)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 11);
  end

  // advance the window on a sample, queue the reply for a request
  function automatic void track_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                                     input logic present, input logic [BYTE_W-1:0] cmd);
    reply_exp_t           r;
    logic [AVG_OUT_W-1:0] avg;
    if (op == OP_SAMPLE) begin
      win_ptr = (win_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : win_ptr + 1'b1;
      win_sum = win_sum - SUM_W'(win_ring[win_ptr]) + SUM_W'(smp);
      win_ring[win_ptr] = smp;
      n_samples++;
    end else begin
      avg = AVG_OUT_W'(win_sum >> AVG_SHIFT);
      if (!present) begin
        r.high = REPLY_EMPTY;
        r.low  = REPLY_EMPTY;
      end else if (cmd == CMD_AVERAGE) begin
        r.high = avg[15:8];
        r.low  = avg[7:0];
      end else begin
        r.high = REPLY_OTHER;
        r.low  = REPLY_OTHER;
      end
      r.length = REPLY_BYTES;
      pending_replies.push_back(r);
      n_requests++;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    reply_exp_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: high %0d low %0d",
               out_reply_high, out_reply_low);
        error_count++;
      end else begin
        r = pending_replies.pop_front();
        check_field("reply_high", 32'(r.high), 32'(out_reply_high));
        check_field("reply_low", 32'(r.low), 32'(out_reply_low));
        check_field("reply_length", 32'(r.length), 32'(out_reply_length));
        n_replies++;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                           input logic present, input logic [BYTE_W-1:0] cmd);
    bit taken;
    @(negedge clk);
    while (!no_idle && ($urandom_range(99) < 11)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op          <= op;
    in_sample      <= smp;
    in_cmd_present <= present;
    in_cmd_byte    <= cmd;
    in_valid       <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    track_item(op, smp, present, cmd);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    send_item(OP_SAMPLE, smp, 1'($urandom), BYTE_W'($urandom));
  endtask

  task automatic send_request(input logic present, input logic [BYTE_W-1:0] cmd);
    send_item(OP_REQUEST, SAMPLE_W'($urandom), present, cmd);
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 15) return '0;
    if (k < 30) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_cmd();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return CMD_AVERAGE;
    // near misses of the average command
    if (k < 80) return CMD_AVERAGE ^ (BYTE_W'(1) << $urandom_range(BYTE_W - 1));
    return BYTE_W'($urandom);
  endfunction

  task automatic test_directed_cases();
    // cleared window, every reply kind, and ignored fields
    send_request(1'b1, CMD_AVERAGE);
    send_request(1'b0, CMD_AVERAGE);
    send_request(1'b0, 8'h00);
    send_request(1'b1, 8'h00);
    send_request(1'b1, 8'hFF);
    send_request(1'b1, 8'h62);
    send_request(1'b1, 8'hE3);
    send_item(OP_SAMPLE, 10'd1023, 1'b1, CMD_AVERAGE);
    send_item(OP_REQUEST, 10'd1023, 1'b1, CMD_AVERAGE);
    send_item(OP_SAMPLE, 10'd0, 1'b0, 8'hFF);
    send_item(OP_SAMPLE, 10'd1, 1'b1, 8'h00);
    send_item(OP_SAMPLE, 10'd512, 1'b0, 8'h00);
    send_item(OP_REQUEST, 10'd0, 1'b1, CMD_AVERAGE);
    send_item(OP_REQUEST, 10'd1023, 1'b1, CMD_AVERAGE);
    send_item(OP_REQUEST, 10'd341, 1'b0, 8'h9C);
    wait_for_replies();
  endtask

  task automatic test_window_extremes();
    // full-scale window, wrap of the ring pointer, then back to zero
    repeat (WINDOW_DEPTH) send_sample('1);
    send_request(1'b1, CMD_AVERAGE);
    send_sample('1);
    send_request(1'b1, CMD_AVERAGE);
    repeat (WINDOW_DEPTH - 1) send_sample('0);
    send_request(1'b1, CMD_AVERAGE);
    send_sample('0);
    send_request(1'b1, CMD_AVERAGE);
    wait_for_replies();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned next_pause;
    sent = 0;
    next_pause = 300;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        // noise: a lone request of any shape
        send_request(1'($urandom_range(99) < 70), BYTE_W'($urandom));
        sent++;
      end else begin
        burst = $urandom_range(1, 40);
        repeat (burst) send_sample(pick_sample());
        send_request(1'($urandom_range(99) < 90), pick_cmd());
        sent += burst + 1;
      end
      if (sent >= next_pause) begin
        // hold off until the block has answered everything
        wait_for_replies();
        next_pause += 300;
      end
    end
    wait_for_replies();
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    no_idle = 1'b1;
    repeat (n_items) begin
      if ($urandom_range(99) < 35) send_request(1'($urandom_range(99) < 85), pick_cmd());
      else send_sample(pick_sample());
    end
    wait_for_replies();
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (win_ring[i]) win_ring[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_window_extremes();
    test_random_traffic(1500);
    test_back_to_back(300);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples and %0d requests, %0d replies compared",
             n_samples, n_requests, n_replies);
    $display("window extremes, pointer wrap, all reply kinds and stalls on both sides");
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending_replies.size() != 0) $error("%0d replies never arrived", pending_replies.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bxa_pkg.sv
rtl/bxa_cell.sv
rtl/bxa_accum.sv
rtl/bxa_reply.sv
rtl/boxcar_average_with_read_port_unit.sv
rtl/bxa_checker.sv
dv/tb.sv
